[sv/smh_pkg.sv]
// Shared types, constants and saturating arithmetic for the stencil matrix-vector unit.
`default_nettype none
package smh_pkg;

   localparam int MAX_COLUMNS_DEFAULT = 1024;
   localparam int DATA_W = 32;
   localparam int ACC_W = 40;
   localparam int ROW_W = 16;
   localparam int REQ_FIELDS = 9;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_BOUNDARY = 2'd2;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic north;
      logic left;
      logic own;
   } emit_ctl_type;

   function automatic acc_type add_sat(input acc_type a, input acc_type b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         add_sat = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         add_sat = s[ACC_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

[sv/smh_ram.sv]
// Generic single-write, single-read RAM with registered read data (read-first).
`default_nettype none
module smh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/smh_qmul.sv]
// Two-stage Q16.16 multiplier: product register, then round half up and clip to 40 bits.
`default_nettype none
module smh_qmul (
   input  logic              clock,
   input  logic              en,
   input  smh_pkg::word_type op_a,
   input  smh_pkg::word_type op_b,
   output smh_pkg::acc_type  result
);
   import smh_pkg::*;

   localparam int PROD_W = 2 * DATA_W;
   localparam int FRAC_W = 16;
   localparam int SHIFT_W = PROD_W - FRAC_W;

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0]        rounded;
   logic [SHIFT_W-1:0]       shifted;
   acc_type                  result_in;
   acc_type                  result_ff;

   always_comb begin
      prod_in = op_a * op_b;
      rounded = prod_ff + (PROD_W'(1) << (FRAC_W - 1));
      shifted = rounded[PROD_W-1:FRAC_W];
      if ((&shifted[SHIFT_W-1:ACC_W-1]) || !(|shifted[SHIFT_W-1:ACC_W-1])) begin
         result_in = shifted[ACC_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         result_in = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         result_in = {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire

[sv/smh_emit.sv]
// Sequencer: holds the up to three results of a point, sends one word a cycle unless stalled.
`default_nettype none
module smh_emit #(
   parameter int COL_W = 10,
   localparam int RSP_DW = ((smh_pkg::DATA_W + COL_W + smh_pkg::ROW_W + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic                       item_valid,
   input  smh_pkg::emit_ctl_type      item_ctl,
   input  smh_pkg::acc_type           partial,
   input  smh_pkg::acc_type           below_q,
   input  smh_pkg::acc_type           left_sum,
   input  smh_pkg::acc_type           own_sum,
   input  logic [COL_W-1:0]           item_col,
   input  logic [smh_pkg::ROW_W-1:0]  item_row,
   output logic                       ready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // product_value, out_column, out_row, zero padding
   output logic [RSP_DW-1:0]          rsp_tdata,
   // saturated
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);
   import smh_pkg::*;

   emit_ctl_type       mask_ff;
   emit_ctl_type       mask_cleared;
   acc_type            north_ff;
   acc_type            left_ff;
   acc_type            own_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;

   logic               out_load;
   logic               few;
   acc_type            sel_val;
   logic [COL_W-1:0]   sel_col;
   logic [ROW_W-1:0]   sel_row;
   logic               sel_done;
   word_type           sat_val;
   logic               sat_flag;

   logic               rsp_valid_ff;
   word_type           rsp_value_ff;
   logic [COL_W-1:0]   rsp_col_ff;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic               rsp_sat_ff;
   logic               rsp_done_ff;

   always_comb begin
      out_load = !rsp_valid_ff || rsp_tready;
      few = !(mask_ff.north && mask_ff.left) && !(mask_ff.north && mask_ff.own) &&
            !(mask_ff.left && mask_ff.own);
      ready = few && ((mask_ff == '0) || out_load);
      mask_cleared = mask_ff;
      if (mask_ff.north) begin
         sel_val = north_ff;
         sel_col = col_ff;
         sel_row = row_ff - ROW_W'(1);
         sel_done = 1'b0;
         mask_cleared.north = 1'b0;
      end else if (mask_ff.left) begin
         sel_val = left_ff;
         sel_col = col_ff - COL_W'(1);
         sel_row = row_ff;
         sel_done = 1'b0;
         mask_cleared.left = 1'b0;
      end else begin
         sel_val = own_ff;
         sel_col = col_ff;
         sel_row = row_ff;
         sel_done = 1'b1;
         mask_cleared.own = 1'b0;
      end
      if ((&sel_val[ACC_W-1:DATA_W-1]) || !(|sel_val[ACC_W-1:DATA_W-1])) begin
         sat_val = sel_val[DATA_W-1:0];
         sat_flag = 1'b0;
      end else begin
         sat_val = sel_val[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
         sat_flag = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            mask_ff <= item_valid ? item_ctl : '0;
         end else if (out_load) begin
            mask_ff <= mask_cleared;
         end
         if (out_load) begin
            rsp_valid_ff <= (mask_ff != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && item_valid) begin
         north_ff <= add_sat(partial, below_q);
         left_ff <= left_sum;
         own_ff <= own_sum;
         col_ff <= item_col;
         row_ff <= item_row;
      end
      if (out_load && (mask_ff != '0)) begin
         rsp_value_ff <= sat_val;
         rsp_col_ff <= sel_col;
         rsp_row_ff <= sel_row;
         rsp_sat_ff <= sat_flag;
         rsp_done_ff <= sel_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_DW'({rsp_row_ff, rsp_col_ff, rsp_value_ff});
   assign rsp_tuser = rsp_sat_ff;
   assign rsp_tlast = rsp_done_ff;

endmodule
`default_nettype wire

[sv/stencil_matvec_halo_unit.sv]
// Top level of the streaming five-point stencil matrix-vector product unit.
`default_nettype none
// The unit takes one grid point per clock in raster order unless stalled and returns, for
// every point, the sum of its west, east, north and south coefficient-times-neighbor products
// in saturated Q16.16; the centre value is not used. A point's result leaves when its last
// operand has arrived, so results of a row appear while the next row streams in, and those
// of the last row appear as that row arrives. Results leave through a registered output at
// one word per clock while rsp_tready is high, which sets the rate: in every row but the last
// each point completes at most one result and points are taken every clock unless the output
// or the write buffer holds them; in the last row most points complete two results, so the
// next point is taken only once the first of them has left. The south operands, north
// coefficients and waiting partial sums live in three line RAMs of MAX_COLUMNS entries with
// registered reads. The partial-sum RAM is read and written in one pipeline stage; the second
// write of a row-end point goes through a one-entry write buffer, and a point that must write
// while that buffer is full waits until the buffer has emptied. The line RAMs are not cleared
// after reset; nothing uses an entry before it is written while the grid size stays fixed.
module stencil_matvec_halo_unit #(
   parameter int MAX_COLUMNS = smh_pkg::MAX_COLUMNS_DEFAULT,
   localparam int COL_W = $clog2(MAX_COLUMNS),
   localparam int CSR_W = (COL_W + 1 > smh_pkg::ROW_W) ? COL_W + 1 : smh_pkg::ROW_W,
   localparam int REQ_DW = smh_pkg::REQ_FIELDS * smh_pkg::DATA_W,
   localparam int RSP_DW = ((smh_pkg::DATA_W + COL_W + smh_pkg::ROW_W + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // point_value, coef_west, coef_east, coef_north, coef_south,
   // halo_west, halo_east, halo_north, halo_south
   input  logic [REQ_DW-1:0]             req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // product_value, out_column, out_row, zero padding
   output logic [RSP_DW-1:0]             rsp_tdata,
   // saturated
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [smh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]              csr_wdata
);
   import smh_pkg::*;

   localparam int NSTAGE = 6;

   logic [COL_W:0]     grid_columns_ff;
   logic [ROW_W-1:0]   grid_rows_ff;
   logic               zero_boundary_ff;

   logic [COL_W-1:0]   col_count_ff;
   logic [ROW_W-1:0]   row_count_ff;
   word_type           left_value_ff;
   word_type           left_east_coef_ff;
   acc_type            left_partial_ff;

   word_type           in_value, in_cw, in_ce, in_cn, in_cs;
   word_type           in_hw, in_he, in_hn, in_hs;
   logic [COL_W:0]     cols_eff;
   logic [ROW_W-1:0]   rows_eff;
   logic [COL_W:0]     col_next;
   logic [ROW_W:0]     row_next;
   logic               last_col;
   logic               last_row;
   logic               en;
   logic               accept;
   logic               emit_ready;

   logic               vld_ff [1:NSTAGE];
   logic [COL_W-1:0]   col_ff [1:NSTAGE];
   logic [ROW_W-1:0]   row_ff [1:NSTAGE];
   logic               lastc_ff [1:NSTAGE];
   logic               lastr_ff [1:NSTAGE];

   word_type           value_s1_ff, cw_s1_ff, ce_s1_ff, cn_s1_ff, cs_s1_ff;
   word_type           he_s1_ff, hn_s1_ff, hs_s1_ff, west_s1_ff, lec_s1_ff;
   logic [DATA_W-1:0]  value_rd;
   logic [DATA_W-1:0]  ncoef_rd;
   word_type           south_op;

   acc_type            q_west, q_south, q_north, q_east, q_left, q_below;
   acc_type            a1_s4_ff, north_s4_ff, east_s4_ff, left_s4_ff, below_s4_ff;
   acc_type            a2_s5_ff, east_s5_ff, left_s5_ff, below_s5_ff;
   acc_type            own_sum, left_sum;
   acc_type            own_s6_ff, left_s6_ff, below_s6_ff;
   logic [ACC_W-1:0]   partial_rd;

   logic               fire5;
   logic               wr_left;
   logic               wr_own;
   logic               hazard;
   logic               pend_valid_ff;
   logic [COL_W-1:0]   pend_addr_ff;
   acc_type            pend_data_ff;
   logic               pl_wr_en;
   logic [COL_W-1:0]   pl_wr_addr;
   acc_type            pl_wr_data;
   emit_ctl_type       item_ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= (COL_W + 1)'(1);
         grid_rows_ff <= ROW_W'(1);
         zero_boundary_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_COLUMNS: grid_columns_ff <= csr_wdata[COL_W:0];
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[ROW_W-1:0];
            CSR_ZERO_BOUNDARY: zero_boundary_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_value = req_tdata[0*DATA_W +: DATA_W];
      in_cw = req_tdata[1*DATA_W +: DATA_W];
      in_ce = req_tdata[2*DATA_W +: DATA_W];
      in_cn = req_tdata[3*DATA_W +: DATA_W];
      in_cs = req_tdata[4*DATA_W +: DATA_W];
      in_hw = zero_boundary_ff ? '0 : req_tdata[5*DATA_W +: DATA_W];
      in_he = zero_boundary_ff ? '0 : req_tdata[6*DATA_W +: DATA_W];
      in_hn = zero_boundary_ff ? '0 : req_tdata[7*DATA_W +: DATA_W];
      in_hs = zero_boundary_ff ? '0 : req_tdata[8*DATA_W +: DATA_W];

      if (grid_columns_ff == '0) begin
         cols_eff = (COL_W + 1)'(1);
      end else if (grid_columns_ff > (COL_W + 1)'(MAX_COLUMNS)) begin
         cols_eff = (COL_W + 1)'(MAX_COLUMNS);
      end else begin
         cols_eff = grid_columns_ff;
      end
      rows_eff = (grid_rows_ff == '0) ? ROW_W'(1) : grid_rows_ff;
      col_next = {1'b0, col_count_ff} + (COL_W + 1)'(1);
      row_next = {1'b0, row_count_ff} + (ROW_W + 1)'(1);
      last_col = (col_next >= cols_eff);
      last_row = (row_next >= {1'b0, rows_eff});
   end

   assign req_tready = en;
   assign accept = req_tvalid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         left_value_ff <= '0;
         left_east_coef_ff <= '0;
      end else if (accept) begin
         left_value_ff <= in_value;
         if (last_col) begin
            col_count_ff <= '0;
            row_count_ff <= last_row ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_count_ff <= col_next[COL_W-1:0];
            left_east_coef_ff <= in_ce;
         end
      end
   end

   smh_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLUMNS)) u_value_line (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_count_ff),
      .wr_data (in_value),
      .rd_en   (accept),
      .rd_addr (col_count_ff),
      .rd_data (value_rd)
   );

   smh_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLUMNS)) u_ncoef_line (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_count_ff),
      .wr_data (in_cn),
      .rd_en   (accept),
      .rd_addr (col_count_ff),
      .rd_data (ncoef_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NSTAGE; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[1] <= req_tvalid;
         for (int k = 2; k <= NSTAGE; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_ff[1] <= col_count_ff;
         row_ff[1] <= row_count_ff;
         lastc_ff[1] <= last_col;
         lastr_ff[1] <= last_row;
         for (int k = 2; k <= NSTAGE; k++) begin
            col_ff[k] <= col_ff[k-1];
            row_ff[k] <= row_ff[k-1];
            lastc_ff[k] <= lastc_ff[k-1];
            lastr_ff[k] <= lastr_ff[k-1];
         end

         value_s1_ff <= in_value;
         cw_s1_ff <= in_cw;
         ce_s1_ff <= in_ce;
         cn_s1_ff <= in_cn;
         cs_s1_ff <= in_cs;
         he_s1_ff <= in_he;
         hn_s1_ff <= in_hn;
         hs_s1_ff <= in_hs;
         west_s1_ff <= (col_count_ff == '0) ? in_hw : left_value_ff;
         lec_s1_ff <= left_east_coef_ff;

         a1_s4_ff <= add_sat(q_west, q_south);
         north_s4_ff <= q_north;
         east_s4_ff <= q_east;
         left_s4_ff <= q_left;
         below_s4_ff <= q_below;

         a2_s5_ff <= lastr_ff[4] ? add_sat(a1_s4_ff, north_s4_ff) : a1_s4_ff;
         east_s5_ff <= east_s4_ff;
         left_s5_ff <= left_s4_ff;
         below_s5_ff <= below_s4_ff;

         own_s6_ff <= own_sum;
         left_s6_ff <= left_sum;
         below_s6_ff <= below_s5_ff;
      end
   end

   assign south_op = (row_ff[1] == '0) ? hs_s1_ff : value_rd;

   smh_qmul u_mul_west (
      .clock(clock), .en(en), .op_a(cw_s1_ff), .op_b(west_s1_ff), .result(q_west)
   );
   smh_qmul u_mul_south (
      .clock(clock), .en(en), .op_a(cs_s1_ff), .op_b(south_op), .result(q_south)
   );
   smh_qmul u_mul_north (
      .clock(clock), .en(en), .op_a(cn_s1_ff), .op_b(hn_s1_ff), .result(q_north)
   );
   smh_qmul u_mul_east (
      .clock(clock), .en(en), .op_a(ce_s1_ff), .op_b(he_s1_ff), .result(q_east)
   );
   smh_qmul u_mul_left (
      .clock(clock), .en(en), .op_a(lec_s1_ff), .op_b(value_s1_ff), .result(q_left)
   );
   smh_qmul u_mul_below (
      .clock(clock), .en(en), .op_a(ncoef_rd), .op_b(value_s1_ff), .result(q_below)
   );

   // The point left of this one gets its east term and is stored unless this is the last row; a
   // row-end point outside the last row also stores its own sum, via the write buffer past column 0.
   always_comb begin
      own_sum = lastc_ff[5] ? add_sat(a2_s5_ff, east_s5_ff) : a2_s5_ff;
      left_sum = add_sat(left_partial_ff, left_s5_ff);
      wr_left = vld_ff[5] && !lastr_ff[5] && (col_ff[5] != '0);
      wr_own = vld_ff[5] && lastc_ff[5] && !lastr_ff[5];
      hazard = pend_valid_ff && (wr_left || wr_own);
      en = emit_ready && !hazard;
      fire5 = en && vld_ff[5];

      if (fire5 && wr_left) begin
         pl_wr_en = 1'b1;
         pl_wr_addr = col_ff[5] - COL_W'(1);
         pl_wr_data = left_sum;
      end else if (fire5 && wr_own) begin
         pl_wr_en = 1'b1;
         pl_wr_addr = col_ff[5];
         pl_wr_data = own_sum;
      end else begin
         pl_wr_en = pend_valid_ff;
         pl_wr_addr = pend_addr_ff;
         pl_wr_data = pend_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         left_partial_ff <= '0;
      end else begin
         if (fire5 && wr_left && wr_own) begin
            pend_valid_ff <= 1'b1;
         end else if (!(fire5 && (wr_left || wr_own))) begin
            pend_valid_ff <= 1'b0;
         end
         if (fire5 && !lastc_ff[5]) begin
            left_partial_ff <= own_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire5 && wr_left && wr_own) begin
         pend_addr_ff <= col_ff[5];
         pend_data_ff <= own_sum;
      end
   end

   smh_ram #(.WIDTH(ACC_W), .DEPTH(MAX_COLUMNS)) u_partial_line (
      .clock   (clock),
      .wr_en   (pl_wr_en),
      .wr_addr (pl_wr_addr),
      .wr_data (pl_wr_data),
      .rd_en   (fire5),
      .rd_addr (col_ff[5]),
      .rd_data (partial_rd)
   );

   always_comb begin
      item_ctl.north = (row_ff[6] != '0);
      item_ctl.left = (col_ff[6] != '0) && lastr_ff[6];
      item_ctl.own = lastc_ff[6] && lastr_ff[6];
   end

   smh_emit #(.COL_W(COL_W)) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (en),
      .item_valid (vld_ff[6]),
      .item_ctl   (item_ctl),
      .partial    (partial_rd),
      .below_q    (below_s6_ff),
      .left_sum   (left_s6_ff),
      .own_sum    (own_s6_ff),
      .item_col   (col_ff[6]),
      .item_row   (row_ff[6]),
      .ready      (emit_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

[tb/stencil_checker.sv]
// Checker for the stencil unit: predicts each product from the accepted words and compares.
module stencil_checker (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   input  logic                                           req_tready,
   input  logic [smh_pkg::REQ_FIELDS*smh_pkg::DATA_W-1:0] req_tdata,
   input  logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   input  logic [63:0]                                    rsp_tdata,
   input  logic                                           rsp_tuser,
   input  logic                                           rsp_tlast,
   input  logic                                           csr_we,
   input  logic [smh_pkg::CSR_IDX_W-1:0]                  csr_index,
   input  logic [15:0]                                    csr_wdata,
   output int                                             fail_count,
   output int                                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import smh_pkg::*;

   localparam int LINE_DEPTH = MAX_COLUMNS_DEFAULT;
   localparam int F_VALUE = 0;
   localparam int F_CW = 1;
   localparam int F_CE = 2;
   localparam int F_CN = 3;
   localparam int F_CS = 4;
   localparam int F_HW = 5;
   localparam int F_HE = 6;
   localparam int F_HN = 7;
   localparam int F_HS = 8;
   localparam longint ACC_HI = (longint'(1) << 39) - 1;
   localparam longint ACC_LO = -(longint'(1) << 39);
   localparam longint Q32_HI = 2147483647;
   localparam longint Q32_LO = -longint'(2147483647) - 1;

   typedef struct packed {
      logic [31:0] product;
      logic [9:0]  column;
      logic [15:0] row;
      logic        saturated;
      logic        done;
   } stencil_result_t;

   stencil_result_t expected_products[$];

   longint      partial_mem [LINE_DEPTH];
   logic [31:0] ncoef_mem [LINE_DEPTH];
   logic [31:0] value_mem [LINE_DEPTH];
   longint      left_acc = 0;
   logic [31:0] left_ecoef = '0;
   logic [31:0] left_val = '0;
   int unsigned col_cnt = 0;
   int unsigned row_cnt = 0;
   logic [10:0] cfg_cols = 11'd1;
   logic [15:0] cfg_rows = 16'd1;
   logic        cfg_zero = 1'b0;
   int          mismatches = 0;

   initial begin
      for (int k = 0; k < LINE_DEPTH; k++) begin
         partial_mem[k] = 0;
         ncoef_mem[k] = '0;
         value_mem[k] = '0;
      end
   end

   function automatic longint clip_acc(input longint v);
      if (v > ACC_HI) return ACC_HI;
      if (v < ACC_LO) return ACC_LO;
      return v;
   endfunction

   // Q16.16 product rounded half up, which is a floor after adding half an LSB.
   function automatic longint round_mul(input logic [31:0] a, input logic [31:0] b);
      longint p;
      p = longint'($signed(a)) * longint'($signed(b)) + 32768;
      return clip_acc(p >>> 16);
   endfunction

   function automatic longint sat_add(input longint a, input longint b);
      return clip_acc(a + b);
   endfunction

   function automatic void queue_product(input longint s, input int unsigned col,
                                         input int unsigned row, input bit done);
      stencil_result_t r;
      r.saturated = 1'b0;
      if (s > Q32_HI) begin
         s = Q32_HI;
         r.saturated = 1'b1;
      end else if (s < Q32_LO) begin
         s = Q32_LO;
         r.saturated = 1'b1;
      end
      r.product = s[31:0];
      r.column = col[9:0];
      r.row = row[15:0];
      r.done = done;
      expected_products.push_back(r);
   endfunction

   task automatic absorb_point(input logic [REQ_FIELDS*DATA_W-1:0] d);
      logic [31:0] v, cw, ce, cn, cs, hw, he, hn, hs;
      int unsigned cols, rows, i, j;
      bit          lastc, lastr;
      longint      own, lp;
      v = d[F_VALUE*32 +: 32];
      cw = d[F_CW*32 +: 32];
      ce = d[F_CE*32 +: 32];
      cn = d[F_CN*32 +: 32];
      cs = d[F_CS*32 +: 32];
      hw = cfg_zero ? '0 : d[F_HW*32 +: 32];
      he = cfg_zero ? '0 : d[F_HE*32 +: 32];
      hn = cfg_zero ? '0 : d[F_HN*32 +: 32];
      hs = cfg_zero ? '0 : d[F_HS*32 +: 32];
      cols = cfg_cols;
      rows = cfg_rows;
      if (cols < 1) cols = 1;
      if (cols > LINE_DEPTH) cols = LINE_DEPTH;
      if (rows < 1) rows = 1;
      i = col_cnt;
      j = row_cnt;
      if (i >= LINE_DEPTH) i = LINE_DEPTH - 1;
      lastc = (i + 1 >= cols);
      lastr = (j + 1 >= rows);

      // This value is the north neighbor of the point one row up.
      if (j > 0) begin
         queue_product(sat_add(partial_mem[i], round_mul(ncoef_mem[i], v)), i, j - 1, 1'b0);
      end

      own = round_mul(cw, (i == 0) ? hw : left_val);
      own = sat_add(own, round_mul(cs, (j == 0) ? hs : value_mem[i]));
      if (lastr) own = sat_add(own, round_mul(cn, hn));

      // This value is the east neighbor of the point to the left.
      if (i > 0) begin
         lp = sat_add(left_acc, round_mul(left_ecoef, v));
         if (lastr) queue_product(lp, i - 1, j, 1'b0);
         else partial_mem[i - 1] = lp;
      end

      if (lastc) begin
         own = sat_add(own, round_mul(ce, he));
         if (lastr) queue_product(own, i, j, 1'b1);
         else partial_mem[i] = own;
      end else begin
         left_acc = own;
         left_ecoef = ce;
      end

      left_val = v;
      value_mem[i] = v;
      ncoef_mem[i] = cn;

      if (lastc) begin
         col_cnt = 0;
         row_cnt = lastr ? 0 : ((j + 1) & 32'hFFFF);
      end else begin
         col_cnt = i + 1;
      end
   endtask

   always @(posedge clock) begin
      stencil_result_t got, want;
      if (reset) begin
         expected_products.delete();
         left_acc = 0;
         left_ecoef = '0;
         left_val = '0;
         col_cnt = 0;
         row_cnt = 0;
         cfg_cols = 11'd1;
         cfg_rows = 16'd1;
         cfg_zero = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_COLUMNS: cfg_cols = csr_wdata[10:0];
               CSR_GRID_ROWS: cfg_rows = csr_wdata[15:0];
               CSR_ZERO_BOUNDARY: cfg_zero = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) absorb_point(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.product = rsp_tdata[31:0];
            got.column = rsp_tdata[41:32];
            got.row = rsp_tdata[57:42];
            got.saturated = rsp_tuser;
            got.done = rsp_tlast;
            if (expected_products.size() == 0) begin
               mismatches++;
               $display("%0t unexpected word: value %h col %0d row %0d sat %0b done %0b",
                        $time, got.product, got.column, got.row, got.saturated, got.done);
            end else begin
               want = expected_products.pop_front();
               if (got !== want) begin
                  mismatches++;
                  $display("%0t mismatch: expected value %h col %0d row %0d sat %0b done %0b",
                           $time, want.product, want.column, want.row, want.saturated,
                           want.done);
                  $display("%0t           actual value %h col %0d row %0d sat %0b done %0b",
                           $time, got.product, got.column, got.row, got.saturated, got.done);
               end
            end
         end
      end
      pending <= expected_products.size();
      fail_count <= mismatches;
   end

endmodule

[tb/tb.sv]
// Top of the stencil unit testbench: clock, reset, stimulus, back-pressure and the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smh_pkg::*;

   localparam int REQ_DW = REQ_FIELDS * DATA_W;
   localparam int RSP_DW = 64;
   localparam int CSR_W = 16;
   localparam int LINE_DEPTH = MAX_COLUMNS_DEFAULT;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_DW-1:0]    req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_DW-1:0]    rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GRID_COLUMNS;
   logic [CSR_W-1:0]     csr_wdata = '0;
   int                   fail_count;
   int                   pending;

   int unsigned eff_cols = 1;
   int unsigned eff_rows = 1;
   int unsigned pos_col = 0;
   int unsigned pos_row = 0;
   int          items_sent = 0;
   bit          steady_send = 1'b0;
   bit          long_hold_armed = 1'b0;

   stencil_matvec_halo_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   stencil_checker product_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] rand_q16();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (r < 3) return $urandom();
      // Mostly values within plus or minus eight, so that sums rarely clip.
      return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
   endfunction

   function automatic logic [REQ_DW-1:0] make_point();
      logic [REQ_DW-1:0] pt;
      for (int k = 0; k < REQ_FIELDS; k++) pt[k*DATA_W +: DATA_W] = rand_q16();
      return pt;
   endfunction

   task automatic send_point(input logic [REQ_DW-1:0] pt);
      int gap;
      gap = steady_send ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pt;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (pos_col + 1 >= eff_cols) begin
         pos_col = 0;
         pos_row = (pos_row + 1 >= eff_rows) ? 0 : pos_row + 1;
      end else begin
         pos_col++;
      end
   endtask

   // Sends up to n random words, stopping early when the grid wraps around.
   task automatic feed_points(input int n);
      int left;
      left = n;
      do begin
         send_point(make_point());
         left--;
      end while (left > 0 && (pos_col != 0 || pos_row != 0));
   endtask

   // Lets the unit drain: every expected word returned, then room for its pipeline.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_GRID_COLUMNS: begin
            eff_cols = val[10:0];
            if (eff_cols == 0) eff_cols = 1;
            if (eff_cols > LINE_DEPTH) eff_cols = LINE_DEPTH;
         end
         CSR_GRID_ROWS: eff_rows = (val[15:0] == 0) ? 1 : val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(input int unsigned cols, input int unsigned rows,
                           input int unsigned zero_edges);
      settle();
      write_reg(CSR_GRID_COLUMNS, cols);
      write_reg(CSR_GRID_ROWS, rows);
      write_reg(CSR_ZERO_BOUNDARY, zero_edges);
   endtask

   initial begin : receiver
      int hold_left;
      int quiet_left;
      int unsigned r;
      hold_left = 0;
      quiet_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            hold_left = 300;
            quiet_left = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (quiet_left > 0) begin
            quiet_left--;
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) quiet_left = $urandom_range(20, 80);
            if (r < 70) begin
               rsp_tready <= 1'b1;
            end else begin
               hold_left = pick_gap();
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned cols_w, rows_w, r;
      bit          mid, first;
      first = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single-point grids left at the reset sizes: positive and negative saturation.
      send_point({REQ_FIELDS{32'h7FFF_FFFF}});
      send_point({{4{32'h7FFF_FFFF}}, {4{32'h8000_0000}}, 32'h7FFF_FFFF});

      set_grid(3, 2, 1);
      feed_points(6);

      // Zero sizes act as a single point.
      set_grid(0, 0, 0);
      repeat (2) feed_points(1);

      // Oversized row length, then shrunk while the first row is still open.
      set_grid(2047, 2, 0);
      feed_points(6);
      settle();
      write_reg(CSR_GRID_COLUMNS, 3);
      feed_points(1 << 30);

      // Tallest grid, cut short by shrinking the row count mid-grid.
      set_grid(2, 65535, 1);
      feed_points(4);
      settle();
      write_reg(CSR_GRID_ROWS, 0);
      feed_points(1 << 30);

      while (items_sent < 406) begin
         r = $urandom_range(0, 19);
         if (r == 0) cols_w = 0;
         else if (r == 1) cols_w = $urandom_range(LINE_DEPTH, 2047);
         else if (r < 5) cols_w = $urandom_range(11, 48);
         else cols_w = $urandom_range(1, 10);
         r = $urandom_range(0, 19);
         if (r == 0) rows_w = 0;
         else if (r == 1) rows_w = $urandom_range(7, 65535);
         else if (cols_w > 10) rows_w = $urandom_range(1, 3);
         else rows_w = $urandom_range(1, 6);
         if (first) begin
            cols_w = 8;
            rows_w = 5;
         end
         set_grid(cols_w, rows_w, $urandom_range(0, 1));
         steady_send = first || ($urandom_range(0, 3) == 0);
         // The receiver stops for a long while so the unit fills up and stalls its input.
         if (first) long_hold_armed = 1'b1;
         first = 1'b0;

         mid = (eff_cols * eff_rows > 60) || ($urandom_range(0, 3) == 0);
         if (mid) begin
            feed_points($urandom_range(1, 30));
            mid = (pos_col != 0 || pos_row != 0);
            if (mid) begin
               // Only shrinking the row length keeps every line entry read already written.
               settle();
               write_reg(CSR_ZERO_BOUNDARY, $urandom_range(0, 1));
               write_reg(CSR_GRID_ROWS, $urandom_range(0, pos_row + 2));
               if (eff_cols > 12) write_reg(CSR_GRID_COLUMNS, $urandom_range(0, 12));
               feed_points(1 << 30);
            end
         end else begin
            feed_points(1 << 30);
         end
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[stencil_matvec_halo_unit.f]
sv/smh_pkg.sv
sv/smh_ram.sv
sv/smh_qmul.sv
sv/smh_emit.sv
sv/stencil_matvec_halo_unit.sv
tb/stencil_checker.sv
tb/tb.sv
